// ===== rtl/bfv_pkg.sv =====
package bfv_pkg;

  localparam int ValueWidth   = 32;
  localparam int FracBits     = 16;

  typedef logic signed [ValueWidth-1:0] val_t;

  localparam val_t MaxV = {1'b0, {(ValueWidth-1){1'b1}}};
  localparam val_t MinV = {1'b1, {(ValueWidth-1){1'b0}}};
  localparam val_t OneV = val_t'(64'sd1 <<< FracBits);
  localparam val_t NegOneV = -OneV;

  typedef enum logic [1:0] {
    KIND_LOAD_VP  = 2'd0,
    KIND_LOAD_OBJ = 2'd1,
    KIND_TEST     = 2'd2,
    KIND_NONE     = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_OBJ,
    ST_VP,
    ST_CHECK,
    ST_OUT
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic       load_box;   // capture box corners, reset extremes
    logic       mac_en;     // do one multiply-accumulate step
    logic       mac_first;  // first term of a row
    logic       obj_pass;   // 1: object row on corner, 0: view row on w
    logic [1:0] row;
    logic [1:0] col;
    logic [2:0] corner;
    logic       row_done;   // store accumulator at end of row
    logic       decide;     // register visible flag
  } cmd_t;

  function automatic val_t sat_add(val_t a, val_t b);
    logic signed [ValueWidth:0] s;
    s = {a[ValueWidth-1], a} + {b[ValueWidth-1], b};
    if (s > $signed({1'b0, MaxV})) return MaxV;
    if (s < $signed({1'b1, MinV})) return MinV;
    return s[ValueWidth-1:0];
  endfunction

  // Product floor-shifted and saturated; arithmetic shift floors.
  function automatic val_t fx_mul(val_t a, val_t b);
    logic signed [2*ValueWidth-1:0] p;
    logic signed [2*ValueWidth-1:0] q;
    p = a * b;
    q = p >>> FracBits;
    if (q > 64'(signed'(MaxV))) return MaxV;
    if (q < 64'(signed'(MinV))) return MinV;
    return q[ValueWidth-1:0];
  endfunction

endpackage

// ===== rtl/bfv_ctrl.sv =====
module bfv_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  logic            out_taken_i,
  output logic            busy_o,
  output logic            out_valid_o,
  output bfv_pkg::cmd_t   cmd_o
);

  bfv_pkg::state_e state_q, state_d;
  logic [1:0] row_q, row_d;
  logic [1:0] col_q, col_d;
  logic [2:0] cor_q, cor_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bfv_pkg::ST_IDLE;
      row_q   <= '0;
      col_q   <= '0;
      cor_q   <= '0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      col_q   <= col_d;
      cor_q   <= cor_d;
    end
  end

  always_comb begin
    state_d = state_q;
    row_d = row_q;
    col_d = col_q;
    cor_d = cor_q;
    cmd_o = '0;
    cmd_o.row = row_q;
    cmd_o.col = col_q;
    cmd_o.corner = cor_q;
    cmd_o.mac_first = (col_q == 2'd0);
    busy_o = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      bfv_pkg::ST_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.load_box = 1'b1;
          row_d = '0; col_d = '0; cor_d = '0;
          state_d = bfv_pkg::ST_OBJ;
        end
      end
      bfv_pkg::ST_OBJ: begin
        cmd_o.mac_en = 1'b1;
        cmd_o.obj_pass = 1'b1;
        col_d = col_q + 2'd1;
        if (col_q == 2'd3) begin
          cmd_o.row_done = 1'b1;
          row_d = row_q + 2'd1;
          if (row_q == 2'd3) begin
            row_d = '0;
            state_d = bfv_pkg::ST_VP;
          end
        end
      end
      bfv_pkg::ST_VP: begin
        cmd_o.mac_en = 1'b1;
        col_d = col_q + 2'd1;
        if (col_q == 2'd3) begin
          cmd_o.row_done = 1'b1;
          row_d = row_q + 2'd1;
          if (row_q == 2'd2) begin
            row_d = '0;
            cor_d = cor_q + 3'd1;
            state_d = (cor_q == 3'd7) ? bfv_pkg::ST_CHECK : bfv_pkg::ST_OBJ;
          end
        end
      end
      bfv_pkg::ST_CHECK: begin
        cmd_o.decide = 1'b1;
        state_d = bfv_pkg::ST_OUT;
      end
      bfv_pkg::ST_OUT: begin
        out_valid_o = 1'b1;
        if (out_taken_i) state_d = bfv_pkg::ST_IDLE;
      end
      default: state_d = bfv_pkg::ST_IDLE;
    endcase
  end

  as_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load_box |-> state_q == bfv_pkg::ST_IDLE)
    else $error("box load outside idle");
  as_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_taken_i |=> out_valid_o)
    else $error("result dropped");
  as_check_after_vp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == bfv_pkg::ST_CHECK |-> $past(state_q) == bfv_pkg::ST_VP)
    else $error("check without final row");

endmodule

// ===== rtl/bfv_dp.sv =====
module bfv_dp (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 wr_vp_i,
  input  logic                 wr_obj_i,
  input  logic [3:0]           wr_idx_i,
  input  logic signed [31:0]   wr_val_i,
  input  logic signed [31:0]   box_i [6],
  input  bfv_pkg::cmd_t        cmd_i,
  output logic                 visible_o
);

  bfv_pkg::val_t vp_q  [16];
  bfv_pkg::val_t obj_q [16];
  bfv_pkg::val_t box_q [6];
  bfv_pkg::val_t w_q   [4];
  bfv_pkg::val_t mn_q  [3];
  bfv_pkg::val_t mx_q  [3];
  bfv_pkg::val_t acc_q, acc_d;
  bfv_pkg::val_t m_ent, v_ent, prod;
  logic [3:0]    idx;
  logic          vis_q;

  always_ff @(posedge clk_i) begin
    if (wr_vp_i)  vp_q[wr_idx_i]  <= bfv_pkg::val_t'(wr_val_i);
    if (wr_obj_i) obj_q[wr_idx_i] <= bfv_pkg::val_t'(wr_val_i);
  end

  assign idx = {cmd_i.row, cmd_i.col};

  always_comb begin
    if (cmd_i.obj_pass) begin
      m_ent = obj_q[idx];
      case (cmd_i.col)
        2'd0:    v_ent = cmd_i.corner[0] ? box_q[3] : box_q[0];
        2'd1:    v_ent = cmd_i.corner[1] ? box_q[4] : box_q[1];
        2'd2:    v_ent = cmd_i.corner[2] ? box_q[5] : box_q[2];
        default: v_ent = bfv_pkg::OneV;
      endcase
    end else begin
      m_ent = vp_q[idx];
      v_ent = w_q[cmd_i.col];
    end
    // w = 1 term adds the entry itself
    if (cmd_i.obj_pass && cmd_i.col == 2'd3) prod = m_ent;
    else prod = bfv_pkg::fx_mul(m_ent, v_ent);
    acc_d = cmd_i.mac_first ? prod : bfv_pkg::sat_add(acc_q, prod);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_box) begin
      for (int i = 0; i < 6; i++) box_q[i] <= bfv_pkg::val_t'(box_i[i]);
      for (int a = 0; a < 3; a++) begin
        mn_q[a] <= bfv_pkg::MaxV;
        mx_q[a] <= bfv_pkg::MinV;
      end
    end
    if (cmd_i.mac_en) acc_q <= acc_d;
    if (cmd_i.row_done) begin
      if (cmd_i.obj_pass) w_q[cmd_i.row] <= acc_d;
      else begin
        if (acc_d < mn_q[cmd_i.row]) mn_q[cmd_i.row] <= acc_d;
        if (acc_d > mx_q[cmd_i.row]) mx_q[cmd_i.row] <= acc_d;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vis_q <= 1'b0;
    else if (cmd_i.decide)
      vis_q <= !(mn_q[2] < 0 || mn_q[2] > bfv_pkg::OneV || mn_q[0] > bfv_pkg::OneV ||
                 mx_q[0] < bfv_pkg::NegOneV || mn_q[1] > bfv_pkg::OneV ||
                 mx_q[1] < bfv_pkg::NegOneV);
  end

  assign visible_o = vis_q;

  as_no_wr_mac: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mac_en |-> !(wr_vp_i || wr_obj_i))
    else $error("matrix write during test");
  as_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.row_done && !cmd_i.obj_pass |-> cmd_i.row != 2'd3)
    else $error("view row out of range");
  as_decide_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.decide |-> !cmd_i.mac_en)
    else $error("decide during mac");

endmodule

// ===== rtl/box_frustum_visibility.sv =====
// Box frustum visibility. Slave transactions carry a kind in s_axis_tuser:
// view-projection entry load (0), object entry load (1), box test (2); kind 3
// is dropped. Loads give no result. A box test transforms its eight corners
// through the object matrix, then rows 0..2 of the view-projection (no w
// divide), tracks per-axis min/max and returns one transaction, visible in
// m_axis_tdata[0]. A single shared multiply-accumulate unit does one term per
// cycle, 4 terms per row, 4 object rows and 3 view rows for each of the 8
// corners; the visibility decision is then registered. Values are Q15.16 with
// floor rounding and saturation. Entries read by a test must be loaded first.
module box_frustum_visibility (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // tdata: entry_index[3:0], entry_value[35:4], box_min_x[67:36],
  // box_min_y[99:68], box_min_z[131:100], box_max_x[163:132],
  // box_max_y[195:164], box_max_z[227:196], zero pad to 232
  input  logic [231:0] s_axis_tdata,
  // tuser: kind[1:0]
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // tdata: visible[0], zero pad
  output logic [7:0]   m_axis_tdata
);

  logic          busy, out_valid, acc, visible;
  bfv_pkg::cmd_t cmd;
  logic signed [31:0] box [6];

  assign s_axis_tready = !busy;
  assign acc = s_axis_tvalid && s_axis_tready;

  always_comb begin
    for (int i = 0; i < 6; i++) box[i] = s_axis_tdata[36+32*i +: 32];
  end

  bfv_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (acc && s_axis_tuser == bfv_pkg::KIND_TEST),
    .out_taken_i (m_axis_tready),
    .busy_o      (busy),
    .out_valid_o (out_valid),
    .cmd_o       (cmd)
  );

  bfv_dp u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_vp_i   (acc && s_axis_tuser == bfv_pkg::KIND_LOAD_VP),
    .wr_obj_i  (acc && s_axis_tuser == bfv_pkg::KIND_LOAD_OBJ),
    .wr_idx_i  (s_axis_tdata[3:0]),
    .wr_val_i  (s_axis_tdata[35:4]),
    .box_i     (box),
    .cmd_i     (cmd),
    .visible_o (visible)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {7'd0, visible};

endmodule
